[rtl/k_way_sorted_run_merger_top_assert.svh]
// Assertion macros for the k-way sorted-run merger.
// Used by k_way_sorted_run_merger_top; expects clk_i and rst_ni in scope.
`ifndef K_WAY_SORTED_RUN_MERGER_TOP_ASSERT_SVH
`define K_WAY_SORTED_RUN_MERGER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KWM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/kwm_pkg.sv]
// Shared types, constants and the double ordering key for the run merger.
// No dependencies; used by all other files of the block except the assertion header.
`timescale 1ns / 1ps

package kwm_pkg;

  localparam int unsigned VAL_W = 64;
  localparam int unsigned RUN_W = 4;

  // Input transaction kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // Scan status toward the control logic
  typedef struct packed {
    logic done;   // best head registers are final
    logic found;  // at least one valid head was seen
  } kwm_scan_stat_t;

  // Map a double bit pattern to an unsigned key that sorts like the double.
  // Both zeros map to the same key.
  function automatic logic [VAL_W-1:0] order_key(input logic [VAL_W-1:0] bits);
    logic [VAL_W-1:0] b;
    b = bits;
    if (b[VAL_W-2:0] == '0) begin
      b = '0;
    end
    if (b[VAL_W-1]) begin
      return ~b;
    end
    return {1'b1, b[VAL_W-2:0]};
  endfunction

endpackage

[rtl/kwm_if.sv]
// Valid/ready channel interfaces for the run merger input and result streams.
// Depends on kwm_pkg for field widths.
`timescale 1ns / 1ps

interface kwm_in_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [kwm_pkg::RUN_W-1:0]  run_index;
  logic [kwm_pkg::VAL_W-1:0]  value;

  modport source (output valid, kind, run_index, value, input ready);
  modport sink   (input valid, kind, run_index, value, output ready);
endinterface

interface kwm_out_if;
  logic                       valid;
  logic                       ready;
  logic [kwm_pkg::VAL_W-1:0]  out_value;
  logic [kwm_pkg::RUN_W-1:0]  out_run;
  logic                       empty_res;

  modport source (output valid, out_value, out_run, empty_res, input ready);
  modport sink   (input valid, out_value, out_run, empty_res, output ready);
endinterface

[rtl/kwm_head_mem.sv]
// Head value store: one write port, one read port, registered read data.
// Depends on kwm_pkg for the value width.
`timescale 1ns / 1ps

module kwm_head_mem #(
  parameter int unsigned RUNS = 16
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(RUNS)-1:0]        waddr_i,
  input  logic [kwm_pkg::VAL_W-1:0]      wdata_i,
  input  logic                           re_i,
  input  logic [$clog2(RUNS)-1:0]        raddr_i,
  output logic [kwm_pkg::VAL_W-1:0]      rdata_o
);

  logic [kwm_pkg::VAL_W-1:0] mem_q [RUNS];
  logic [kwm_pkg::VAL_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/kwm_min_scan.sv]
// Minimum search: walks the head memory one entry per cycle through a single
// key comparator and keeps the smallest valid head. Depends on kwm_pkg.
`timescale 1ns / 1ps

module kwm_min_scan #(
  parameter int unsigned RUNS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [RUNS-1:0]                head_vld_i,
  output logic                           rd_en_o,
  output logic [$clog2(RUNS)-1:0]        rd_addr_o,
  input  logic [kwm_pkg::VAL_W-1:0]      rd_data_i,
  output kwm_pkg::kwm_scan_stat_t        stat_o,
  output logic [$clog2(RUNS)-1:0]        best_idx_o,
  output logic [kwm_pkg::VAL_W-1:0]      best_val_o
);

  localparam int unsigned IW = $clog2(RUNS);
  localparam logic [IW-1:0] LAST_IDX = IW'(RUNS - 1);

  logic                      issue_q, issue_d;
  logic [IW-1:0]             cnt_q, cnt_d;
  logic                      pend_q, pend_d;
  logic                      pend_last_q, pend_last_d;
  logic [IW-1:0]             pend_idx_q;
  logic                      done_q, done_d;
  logic                      found_q, found_d;
  logic [IW-1:0]             best_idx_q;
  logic [kwm_pkg::VAL_W-1:0] best_val_q;
  logic                      take_cand;

  // Address issue
  assign rd_en_o   = issue_q;
  assign rd_addr_o = cnt_q;

  // Candidate wins on strictly smaller key, so ties keep the lower run
  assign take_cand = pend_q && head_vld_i[pend_idx_q] &&
                     (!found_q ||
                      (kwm_pkg::order_key(rd_data_i) < kwm_pkg::order_key(best_val_q)));

  always_comb begin
    issue_d     = issue_q;
    cnt_d       = cnt_q;
    pend_d      = issue_q;
    pend_last_d = issue_q && (cnt_q == LAST_IDX);
    done_d      = pend_q && pend_last_q;
    found_d     = found_q || take_cand;
    if (start_i) begin
      issue_d = 1'b1;
      cnt_d   = '0;
      found_d = 1'b0;
    end else if (issue_q) begin
      if (cnt_q == LAST_IDX) begin
        issue_d = 1'b0;
      end else begin
        cnt_d = cnt_q + IW'(1);
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q     <= 1'b0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      done_q      <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      issue_q     <= issue_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
      done_q      <= done_d;
      found_q     <= found_d;
    end
  end

  // Track read index and hold the running best
  always_ff @(posedge clk_i) begin
    pend_idx_q <= cnt_q;
    if (take_cand) begin
      best_idx_q <= pend_idx_q;
      best_val_q <= rd_data_i;
    end
  end

  assign stat_o.done  = done_q;
  assign stat_o.found = found_q;
  assign best_idx_o   = best_idx_q;
  assign best_val_o   = best_val_q;

endmodule

[rtl/k_way_sorted_run_merger_top.sv]
// Top level of the k-way sorted-run merger: input control, head valid bits,
// result register. Depends on kwm_pkg, kwm_if, kwm_head_mem, kwm_min_scan.
//
//   channel   dir   fields                          transaction
//   in_if     in    kind, run_index, value          load head or pop minimum
//   out_if    out   out_value, out_run, empty_res   one per pop
//
// A load writes the head memory and the run's valid bit.
// A pop walks the head memory through its single read port into one key
// comparator and then hands the smallest valid head to the result register.
// Reset clears all valid bits; head memory contents are left as they are.
// Input is taken only while no pop is in flight; a finished result waits in
// the output register while further loads are taken.
`timescale 1ns / 1ps
`include "k_way_sorted_run_merger_top_assert.svh"

module k_way_sorted_run_merger_top #(
  parameter int unsigned RUNS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kwm_in_if.sink    in_if,
  kwm_out_if.source out_if
);

  localparam int unsigned IW    = $clog2(RUNS);
  localparam int unsigned RUN_W = kwm_pkg::RUN_W;
  localparam logic [31:0] RUNS_U = 32'(RUNS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]                state_q, state_d;
  logic [RUNS-1:0]           head_vld_q, head_vld_d;
  logic                      out_valid_q, out_valid_d;
  logic [kwm_pkg::VAL_W-1:0] out_value_q;
  logic [RUN_W-1:0]          out_run_q;
  logic                      out_empty_q;

  logic                      in_fire, is_load, is_pop, in_range, load_we, scan_start, emit_go;
  logic [IW+RUN_W-1:0]       ld_ext;
  logic [IW-1:0]             ld_addr;
  logic [IW+RUN_W-1:0]       best_ext;

  logic                      rd_en;
  logic [IW-1:0]             rd_addr;
  logic [kwm_pkg::VAL_W-1:0] rd_data;
  kwm_pkg::kwm_scan_stat_t   scan_stat;
  logic [IW-1:0]             scan_best_idx;
  logic [kwm_pkg::VAL_W-1:0] scan_best_val;

  // Input decode
  assign in_if.ready = (state_q == ST_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign is_load     = (in_if.kind == kwm_pkg::KIND_LOAD);
  assign is_pop      = (in_if.kind == kwm_pkg::KIND_POP);
  assign in_range    = (32'(in_if.run_index) < RUNS_U);
  assign ld_ext      = {{IW{1'b0}}, in_if.run_index};
  assign ld_addr     = ld_ext[IW-1:0];
  assign load_we     = in_fire && is_load && in_range;
  assign scan_start  = in_fire && is_pop;

  // Hand the result over once the output register is free or draining
  assign emit_go  = (state_q == ST_EMIT) && (!out_valid_q || out_if.ready);
  assign best_ext = {{RUN_W{1'b0}}, scan_best_idx};

  kwm_head_mem #(
    .RUNS (RUNS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (ld_addr),
    .wdata_i (in_if.value),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  kwm_min_scan #(
    .RUNS (RUNS)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (scan_start),
    .head_vld_i (head_vld_q),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .stat_o     (scan_stat),
    .best_idx_o (scan_best_idx),
    .best_val_o (scan_best_val)
  );

  // Sequence: idle, scan, emit
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (scan_start) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_stat.done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Set valid on load, drop the popped run's valid bit
  always_comb begin
    head_vld_d = head_vld_q;
    if (load_we) begin
      head_vld_d[ld_addr] = 1'b1;
    end
    if (emit_go && scan_stat.found) begin
      head_vld_d[scan_best_idx] = 1'b0;
    end
  end

  // Output register occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_go) begin
      out_valid_d = 1'b1;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_vld_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_vld_q  <= head_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload; empty pops report zero value and run
  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      if (scan_stat.found) begin
        out_value_q <= scan_best_val;
        out_run_q   <= best_ext[RUN_W-1:0];
        out_empty_q <= 1'b0;
      end else begin
        out_value_q <= '0;
        out_run_q   <= '0;
        out_empty_q <= 1'b1;
      end
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.out_value = out_value_q;
  assign out_if.out_run   = out_run_q;
  assign out_if.empty_res = out_empty_q;

  // Checks
  `KWM_ASSERT_NEXT(a_pop_blocks_input, scan_start, !in_if.ready, "input open during pop")
  `KWM_ASSERT_SAME(a_done_in_scan, scan_stat.done, state_q == ST_SCAN, "scan done outside scan")
  `KWM_ASSERT_NEXT(a_pop_clears_valid, emit_go && scan_stat.found, !head_vld_q[$past(scan_best_idx)], "popped head still valid")

endmodule
